@@ src/utf8_to_utf16_converter_defines.svh @@
// Assertion macros for the checker file.
`ifndef UTF8_TO_UTF16_CONVERTER_DEFINES_SVH
`define UTF8_TO_UTF16_CONVERTER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication, off while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

@@ src/u8u16_pkg.sv @@
`default_nettype none

package u8u16_pkg;

	// result kinds
	localparam logic [1:0] KIND_UNIT = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;
	localparam logic [1:0] KIND_FULL = 2'd3;

	localparam logic [9:0]  MAX_UNITS_RESET = 10'd511;
	localparam logic [15:0] SURR_HIGH       = 16'hD800;
	localparam logic [15:0] SURR_LOW        = 16'hDC00;
	localparam logic [20:0] SUPP_BASE       = 21'h10000;

	// result queue
	localparam int unsigned FIFO_AW    = 2;
	localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

	typedef struct packed {
		logic [15:0] unit;
		logic [1:0]  end_kind;
		logic [9:0]  unit_count;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

@@ src/u8u16_byte_if.sv @@
`default_nettype none

interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ src/u8u16_unit_if.sv @@
`default_nettype none

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] unit;
	logic [1:0]  end_kind;
	logic [9:0]  unit_count;
	logic        last;

	modport source (output valid, output unit, output end_kind, output unit_count,
		output last, input ready);
	modport sink (input valid, input unit, input end_kind, input unit_count,
		input last, output ready);
endinterface

`default_nettype wire

@@ src/utf8_to_utf16_converter.sv @@
// Path: a byte taken on src_bytes passes the input register, then the result queue,
//   before its result is offered on utf16_units.
// Throughput: one byte per cycle while the queue has room; a surrogate pair is two
//   results; sustained rate is set by the single result pop per cycle of the queue.
// Reset (arst_n low, asynchronous): decoder state cleared, queue emptied,
//   max_units back to 511.
`default_nettype none

module utf8_to_utf16_converter #(
	parameter int unsigned MAX_CAPACITY = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [9:0] cfg_wdata,
	u8u16_byte_if.sink      src_bytes,
	u8u16_unit_if.source    utf16_units
);

	localparam int unsigned CW = u8u16_pkg::FIFO_AW + 1;
	// Hard cap on the per-string capacity; only bites when below the 10-bit range.
	localparam logic [16:0] CAP_LIMIT = 17'(MAX_CAPACITY - 1);

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [9:0] max_units_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= u8u16_pkg::MAX_UNITS_RESET;
		end else if (cfg_we) begin
			max_units_q <= cfg_wdata;
		end
	end

	logic [9:0] cap_eff;
	assign cap_eff = ({7'b0, max_units_q} > CAP_LIMIT) ? CAP_LIMIT[9:0] : max_units_q;

	// ---------------------------------------------------------------
	// Input register: one byte parked here, decoded next cycle once the
	// result queue has room for the worst case (two results).
	// ---------------------------------------------------------------
	logic [CW-1:0] count_q;
	logic          v_s1;
	logic [7:0]    byte_s1;
	logic          room;
	logic          advance;
	logic          in_take;

	assign room      = count_q <= CW'(u8u16_pkg::FIFO_DEPTH - 2);
	assign advance   = v_s1 && room;
	assign src_bytes.ready = !v_s1 || room;
	assign in_take   = src_bytes.valid && src_bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= src_bytes.in_byte;
		end
	end

	// ---------------------------------------------------------------
	// Decoder state
	// ---------------------------------------------------------------
	logic [20:0] acc_q;
	logic [1:0]  pend_q;
	logic [9:0]  units_q;
	logic        disc_q;

	logic [20:0] nxt_acc;
	logic [1:0]  nxt_pend;
	logic [9:0]  nxt_units;
	logic        nxt_disc;
	logic [1:0]  n_push;
	u8u16_pkg::result_t r0;
	u8u16_pkg::result_t r1;

	logic        complete;
	logic [20:0] comp_code;
	logic [20:0] shifted;
	logic        need2;
	logic [10:0] need_sum;
	logic [20:0] supp;

	assign shifted  = {acc_q[14:0], byte_s1[5:0]};
	assign need2    = comp_code[20:16] != 5'd0;
	assign need_sum = {1'b0, units_q} + (need2 ? 11'd2 : 11'd1);
	assign supp     = comp_code - u8u16_pkg::SUPP_BASE;

	always_comb begin
		nxt_acc   = acc_q;
		nxt_pend  = pend_q;
		nxt_units = units_q;
		nxt_disc  = disc_q;
		n_push    = 2'd0;
		r0        = '0;
		r1        = '0;
		complete  = 1'b0;
		comp_code = '0;

		if (disc_q) begin
			// dropping bytes; NUL resynchronizes silently
			if (byte_s1 == 8'd0) begin
				nxt_disc  = 1'b0;
				nxt_acc   = '0;
				nxt_pend  = '0;
				nxt_units = '0;
			end
		end else if (byte_s1 == 8'd0) begin
			// end of string; NUL inside a sequence counts as invalid
			r0.end_kind   = (pend_q != 2'd0) ? u8u16_pkg::KIND_BAD : u8u16_pkg::KIND_END;
			r0.unit_count = units_q;
			r0.last       = 1'b1;
			n_push        = 2'd1;
			nxt_acc       = '0;
			nxt_pend      = '0;
			nxt_units     = '0;
		end else if (pend_q != 2'd0) begin
			if (byte_s1[7:6] != 2'b10) begin
				r0.end_kind   = u8u16_pkg::KIND_BAD;
				r0.unit_count = units_q;
				r0.last       = 1'b1;
				n_push        = 2'd1;
				nxt_acc       = '0;
				nxt_pend      = '0;
				nxt_units     = '0;
				nxt_disc      = 1'b1;
			end else begin
				nxt_pend = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					complete  = 1'b1;
					comp_code = shifted;
				end else begin
					nxt_acc = shifted;
				end
			end
		end else if (!byte_s1[7]) begin
			complete  = 1'b1;
			comp_code = {13'd0, byte_s1};
		end else if (byte_s1[7:5] == 3'b110) begin
			nxt_acc  = {16'd0, byte_s1[4:0]};
			nxt_pend = 2'd1;
		end else if (byte_s1[7:4] == 4'b1110) begin
			nxt_acc  = {17'd0, byte_s1[3:0]};
			nxt_pend = 2'd2;
		end else begin
			// every other pattern is taken as a four-byte lead
			nxt_acc  = {18'd0, byte_s1[2:0]};
			nxt_pend = 2'd3;
		end

		if (complete) begin
			nxt_acc = '0;
			if (need_sum > {1'b0, cap_eff}) begin
				r0.end_kind   = u8u16_pkg::KIND_FULL;
				r0.unit_count = units_q;
				r0.last       = 1'b1;
				n_push        = 2'd1;
				nxt_pend      = '0;
				nxt_units     = '0;
				nxt_disc      = 1'b1;
			end else if (!need2) begin
				r0.unit   = comp_code[15:0];
				r0.last   = 1'b1;
				n_push    = 2'd1;
				nxt_units = units_q + 10'd1;
			end else begin
				// surrogate pair; codes past 0x10FFFF spill the high unit into the low range
				r0.unit   = u8u16_pkg::SURR_HIGH | {5'd0, supp[20:10]};
				r0.last   = 1'b0;
				r1.unit   = u8u16_pkg::SURR_LOW | {6'd0, supp[9:0]};
				r1.last   = 1'b1;
				n_push    = 2'd2;
				nxt_units = units_q + 10'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			pend_q  <= '0;
			units_q <= '0;
			disc_q  <= 1'b0;
		end else if (advance) begin
			acc_q   <= nxt_acc;
			pend_q  <= nxt_pend;
			units_q <= nxt_units;
			disc_q  <= nxt_disc;
		end
	end

	// ---------------------------------------------------------------
	// Result queue: up to two writes, one read per cycle. The head entry
	// drives utf16_units directly and holds while the sink stalls.
	// ---------------------------------------------------------------
	u8u16_pkg::result_t fifo_q [u8u16_pkg::FIFO_DEPTH];
	logic [u8u16_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [u8u16_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [1:0] push;
	logic       pop;

	assign push = advance ? n_push : 2'd0;
	assign pop  = utf16_units.valid && utf16_units.ready;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (push == 2'd2) begin
			fifo_q[wr_ptr_q + u8u16_pkg::FIFO_AW'(1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + u8u16_pkg::FIFO_AW'(push);
			rd_ptr_q <= rd_ptr_q + u8u16_pkg::FIFO_AW'(pop);
			count_q  <= count_q + CW'(push) - CW'(pop);
		end
	end

	u8u16_pkg::result_t head;
	assign head = fifo_q[rd_ptr_q];

	assign utf16_units.valid      = count_q != '0;
	assign utf16_units.unit       = head.unit;
	assign utf16_units.end_kind   = head.end_kind;
	assign utf16_units.unit_count = head.unit_count;
	assign utf16_units.last       = head.last;

endmodule

`default_nettype wire

@@ src/u8u16_checker.sv @@
`default_nettype none
`include "utf8_to_utf16_converter_defines.svh"

module u8u16_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] unit,
	input wire logic [1:0]  end_kind,
	input wire logic [9:0]  unit_count,
	input wire logic        last
);

	// stalled result holds
	`U8U16_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(unit) && $stable(end_kind) && $stable(unit_count) && $stable(last))

	// high surrogate is always followed at once by its low half
	`U8U16_ASSERT_NEXT(a_pair, clk, arst_n, out_valid && out_ready && !last, out_valid && last && unit[15:10] == 6'b110111 && end_kind == u8u16_pkg::KIND_UNIT)

	// a non-final result is only ever a surrogate-range unit
	`U8U16_ASSERT_IMPLY(a_high, clk, arst_n, out_valid && !last, unit[15:11] == 5'b11011 && end_kind == u8u16_pkg::KIND_UNIT && unit_count == 10'd0)

	// end results carry no unit and close the transaction group
	`U8U16_ASSERT_IMPLY(a_end, clk, arst_n, out_valid && end_kind != u8u16_pkg::KIND_UNIT, unit == 16'd0 && last)

endmodule

bind utf8_to_utf16_converter u8u16_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (utf16_units.valid),
	.out_ready  (utf16_units.ready),
	.unit       (utf16_units.unit),
	.end_kind   (utf16_units.end_kind),
	.unit_count (utf16_units.unit_count),
	.last       (utf16_units.last)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_CAPACITY = 1024;
	localparam int WATCHDOG_LIMIT = 4000;   // idle cycles with no transaction on either side
	localparam int SETTLE_CYCLES = 8;       // margin after the expected results have drained
	localparam int PHASE_COUNT = 12;
	localparam int PHASE_BYTES = 125;
	localparam int REPORT_LIMIT = 10;

	// Hand-picked bytes, all at reset capacity (511):
	//   ASCII 'A' and max, 2/3/4-byte codes, overlong zero, lone surrogate,
	//   max BMP, surrogate pair, out-of-range 4-byte lead (code 0x1FFFFF),
	//   normal end, NUL inside a sequence, bad continuation then discard.
	localparam int DIRECTED_LEN = 27;
	localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
		8'h41, 8'h7F,
		8'hC3, 8'hA9,
		8'hC0, 8'h80,
		8'hED, 8'hA0, 8'h80,
		8'hEF, 8'hBF, 8'hBF,
		8'hF0, 8'h9F, 8'h98, 8'h80,
		8'hFF, 8'hBF, 8'hBF, 8'hBF,
		8'h00,
		8'hC3, 8'h00,
		8'hE2, 8'h41, 8'h42, 8'h00
	};

	// Capacity per random phase; extremes repeat so they meet more than one idling mode.
	localparam logic [9:0] PHASE_CAP [PHASE_COUNT] = '{
		10'd1023, 10'd0, 10'd1, 10'd2, 10'd3, 10'd511,
		10'd4, 10'd1023, 10'd0, 10'd6, 10'd2, 10'd9
	};

	// Predicts the UTF-16 stream for accepted bytes and checks what comes out.
	class utf16_scoreboard;
		u8u16_pkg::result_t expected_q[$];
		logic [20:0] partial_code = '0;
		logic [1:0]  cont_left = '0;
		logic [9:0]  units_out = '0;
		bit          skip_to_nul = 1'b0;
		logic [9:0]  capacity = u8u16_pkg::MAX_UNITS_RESET;
		int          errors = 0;
		int          results_seen = 0;
		int          pairs = 0;
		int          ends_by_kind[4] = '{0, 0, 0, 0};

		function void flag_error(string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("mismatch @%0t: %s", $realtime, msg);
		endfunction

		function void set_capacity(logic [9:0] v);
			capacity = v;
		endfunction

		function void clear_string();
			partial_code = '0;
			cont_left = '0;
			units_out = '0;
		endfunction

		function void expect_result(logic [15:0] u, logic [1:0] k, logic [9:0] c, logic l);
			u8u16_pkg::result_t r;
			r.unit = u;
			r.end_kind = k;
			r.unit_count = c;
			r.last = l;
			expected_q.push_back(r);
		endfunction

		// One accepted byte -> zero, one or two expected results.
		function void note_byte(logic [7:0] b);
			logic [20:0] code;
			logic [20:0] offset;
			int          cap;
			int          need;
			if (skip_to_nul) begin
				if (b == 8'h00) begin
					skip_to_nul = 1'b0;
					clear_string();
				end
				return;
			end
			if (b == 8'h00) begin
				// NUL mid-sequence is an invalid end, never a terminator
				expect_result('0, (cont_left != 0) ? u8u16_pkg::KIND_BAD : u8u16_pkg::KIND_END,
					units_out, 1'b1);
				clear_string();
				return;
			end
			if (cont_left != 0) begin
				if (b[7:6] != 2'b10) begin
					expect_result('0, u8u16_pkg::KIND_BAD, units_out, 1'b1);
					clear_string();
					skip_to_nul = 1'b1;
					return;
				end
				partial_code = {partial_code[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left != 0)
					return;
			end else if (!b[7]) begin
				partial_code = {13'd0, b};
			end else if (b[7:5] == 3'b110) begin
				partial_code = {16'd0, b[4:0]};
				cont_left = 2'd1;
				return;
			end else if (b[7:4] == 4'b1110) begin
				partial_code = {17'd0, b[3:0]};
				cont_left = 2'd2;
				return;
			end else begin
				// any other lead, stray continuation included, opens a 4-byte code
				partial_code = {18'd0, b[2:0]};
				cont_left = 2'd3;
				return;
			end

			code = partial_code;
			partial_code = '0;
			cap = (int'(capacity) > MAX_CAPACITY - 1) ? MAX_CAPACITY - 1 : int'(capacity);
			need = (code >= u8u16_pkg::SUPP_BASE) ? 2 : 1;
			if (int'(units_out) + need > cap) begin
				expect_result('0, u8u16_pkg::KIND_FULL, units_out, 1'b1);
				clear_string();
				skip_to_nul = 1'b1;
				return;
			end
			if (need == 1) begin
				expect_result(code[15:0], u8u16_pkg::KIND_UNIT, '0, 1'b1);
				units_out = units_out + 10'd1;
			end else begin
				offset = code - u8u16_pkg::SUPP_BASE;
				expect_result(u8u16_pkg::SURR_HIGH | {5'd0, offset[20:10]},
					u8u16_pkg::KIND_UNIT, '0, 1'b0);
				expect_result(u8u16_pkg::SURR_LOW | {6'd0, offset[9:0]},
					u8u16_pkg::KIND_UNIT, '0, 1'b1);
				units_out = units_out + 10'd2;
				pairs++;
			end
		endfunction

		function void check_result(u8u16_pkg::result_t got);
			u8u16_pkg::result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				flag_error($sformatf("unexpected result unit=%h kind=%0d count=%0d last=%b",
					got.unit, got.end_kind, got.unit_count, got.last));
				return;
			end
			want = expected_q.pop_front();
			if (got.unit !== want.unit || got.end_kind !== want.end_kind ||
					got.unit_count !== want.unit_count || got.last !== want.last)
				flag_error($sformatf({"exp unit=%h kind=%0d count=%0d last=%b, ",
					"got unit=%h kind=%0d count=%0d last=%b"},
					want.unit, want.end_kind, want.unit_count, want.last,
					got.unit, got.end_kind, got.unit_count, got.last));
			ends_by_kind[want.end_kind]++;
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we;
	logic [9:0] cfg_wdata;

	u8u16_byte_if byte_bus();
	u8u16_unit_if unit_bus();

	utf16_scoreboard sb;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int bytes_sent = 0;
	int cap_writes = 0;
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	utf8_to_utf16_converter #(
		.MAX_CAPACITY(MAX_CAPACITY)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.src_bytes  (byte_bus),
		.utf16_units(unit_bus)
	);

	// Output side: check each transaction against the oldest prediction,
	// then draw the next cycle's ready from the current stall rate.
	always @(posedge clk) begin
		if (!arst_n) begin
			unit_bus.ready <= 1'b0;
		end else begin
			if (unit_bus.valid && unit_bus.ready)
				sb.check_result({unit_bus.unit, unit_bus.end_kind,
					unit_bus.unit_count, unit_bus.last});
			unit_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_bus.valid && byte_bus.ready) || (unit_bus.valid && unit_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results still due",
					WATCHDOG_LIMIT, sb.expected_q.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// One byte transaction. valid stays high between back-to-back bytes;
	// it only drops on an idle cycle or in settle().
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(posedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.in_byte <= b;
		@(posedge clk);
		while (!byte_bus.ready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Stop sending and wait for every predicted result, plus a settling margin in
	// case the last bytes were ones that produce nothing.
	task automatic settle();
		byte_bus.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called right after settle(), so the block is idle.
	task automatic write_capacity(input logic [9:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
		cap_writes++;
	endtask

	// A random string of n_chars characters plus NUL. Noisy strings may cut a
	// sequence short, insert a stray byte, or end with NUL right after a lead.
	task automatic send_string(input int n_chars, input bit noisy);
		int         k;
		int         sel;
		int         n_cont;
		logic [7:0] lead;
		for (k = 0; k < n_chars; k++) begin
			sel = int'($urandom_range(0, 9));
			if (sel < 4) begin
				lead = 8'($urandom_range(1, 127));
				n_cont = 0;
			end else if (sel < 6) begin
				lead = 8'hC0 | 8'($urandom_range(0, 31));
				n_cont = 1;
			end else if (sel < 8) begin
				lead = 8'hE0 | 8'($urandom_range(0, 15));
				n_cont = 2;
			end else begin
				// F8..FF included: still a 4-byte lead
				lead = 8'hF0 | 8'($urandom_range(0, 15));
				n_cont = 3;
			end
			if (noisy && $urandom_range(0, 9) == 0)
				n_cont = int'($urandom_range(0, n_cont));
			send_byte(lead);
			repeat (n_cont) send_byte(8'h80 | 8'($urandom_range(0, 63)));
			if (noisy && $urandom_range(0, 19) == 0)
				send_byte(8'($urandom_range(0, 255)));
		end
		if (noisy && $urandom_range(0, 7) == 0)
			send_byte(8'hC0 | 8'($urandom_range(0, 63)));
		send_byte(8'h00);
	endtask

	initial begin
		int p;
		int i;
		int phase_end;
		sb = new;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		byte_bus.valid = 1'b0;
		byte_bus.in_byte = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed bytes at reset capacity, no idling
		for (i = 0; i < DIRECTED_LEN; i++)
			send_byte(DIRECTED_BYTES[i]);

		// capacity of one: a surrogate pair does not fit, the NUL after it is
		// swallowed by the discard, then a single unit fits and ends normally
		settle();
		write_capacity(10'd1);
		send_byte(8'hF0);
		send_byte(8'h9F);
		send_byte(8'h98);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h41);
		send_byte(8'h00);

		// random phases: mostly well-formed strings, a quarter noisy;
		// idling mode cycles none / sender / receiver / both
		for (p = 0; p < PHASE_COUNT; p++) begin
			settle();
			write_capacity(PHASE_CAP[p]);
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 64;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 64;
				end
				default: begin
					sender_idle_pct = 32;
					receiver_stall_pct = 32;
				end
			endcase
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(0, 15) == 0)
					send_string(int'($urandom_range(11, 60)), $urandom_range(0, 3) == 0);
				else
					send_string(int'($urandom_range(0, 10)), $urandom_range(0, 3) == 0);
			end
		end

		settle();
		if (sb.expected_q.size() != 0)
			sb.flag_error($sformatf("%0d expected results never arrived",
				sb.expected_q.size()));

		$display("tb: %0d bytes in, %0d results out, %0d capacity writes (0 to 1023)",
			bytes_sent, sb.results_seen, cap_writes);
		$display("tb: ends normal/invalid/capacity %0d/%0d/%0d, surrogate pairs %0d",
			sb.ends_by_kind[u8u16_pkg::KIND_END], sb.ends_by_kind[u8u16_pkg::KIND_BAD],
			sb.ends_by_kind[u8u16_pkg::KIND_FULL], sb.pairs);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
